### rtl/core/source_char_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_CHAR_TOKENIZER_DEFINES_SVH
`define SOURCE_CHAR_TOKENIZER_DEFINES_SVH

// Same-cycle implication.
`define SCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sct_pkg.sv
`default_nettype none

package sct_pkg;

  localparam int PositionBitsDef = 16;

  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeNumber  = 3'd1;
  localparam logic [2:0] ModeIdent   = 3'd2;
  localparam logic [2:0] ModeText    = 3'd3;
  localparam logic [2:0] ModeSlash   = 3'd4;
  localparam logic [2:0] ModeComment = 3'd5;
  localparam logic [2:0] ModeError   = 3'd6;

  typedef enum logic [2:0] {
    KindLparen = 3'd0,
    KindRparen = 3'd1,
    KindIdent  = 3'd2,
    KindSemi   = 3'd3,
    KindEquals = 3'd4,
    KindNumber = 3'd5,
    KindText   = 3'd6,
    KindError  = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ErrNone         = 2'd0,
    ErrUnknown      = 2'd1,
    ErrLoneSlash    = 2'd2,
    ErrUnterminated = 2'd3
  } err_e;

  localparam logic [7:0] ChQuote      = 8'h22;
  localparam logic [7:0] ChSlash      = 8'h2F;
  localparam logic [7:0] ChSemi       = 8'h3B;
  localparam logic [7:0] ChEquals     = 8'h3D;
  localparam logic [7:0] ChLparen     = 8'h28;
  localparam logic [7:0] ChRparen     = 8'h29;
  localparam logic [7:0] ChNewline    = 8'h0A;
  localparam logic [7:0] ChUnderscore = 8'h5F;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    kind_e       kind;
    err_e        err;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

`default_nettype wire

### rtl/core/sct_step.sv
`default_nettype none

module sct_step #(
  parameter int PosBits = sct_pkg::PositionBitsDef
) (
  input  wire logic [7:0]         ch_i,
  input  wire logic               eos_i,
  input  wire logic [2:0]         mode_i,
  input  wire logic [15:0]        run_len_i,
  input  wire logic [PosBits-1:0] line_i,
  input  wire logic [PosBits-1:0] col_i,
  input  wire logic [PosBits-1:0] prev_line_i,
  input  wire logic [PosBits-1:0] prev_col_i,
  output logic [2:0]              mode_o,
  output logic [15:0]             run_len_o,
  output logic [PosBits-1:0]      line_o,
  output logic [PosBits-1:0]      col_o,
  output logic [PosBits-1:0]      prev_line_o,
  output logic [PosBits-1:0]      prev_col_o,
  output sct_pkg::push_t          push_o
);

  localparam int SatW = (PosBits > 16) ? PosBits : 16;

  function automatic logic [15:0] sat16(input logic [PosBits-1:0] v);
    logic [SatW-1:0] ext;
    ext = SatW'(v);
    return (ext > SatW'(17'h0FFFF)) ? 16'hFFFF : ext[15:0];
  endfunction

  function automatic logic [PosBits-1:0] pos_inc(input logic [PosBits-1:0] v);
    return (v == {PosBits{1'b1}}) ? v : v + PosBits'(1);
  endfunction

  function automatic logic [15:0] len_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic sct_pkg::result_t mk(input sct_pkg::kind_e k, input sct_pkg::err_e e,
                                          input logic [PosBits-1:0] ln,
                                          input logic [PosBits-1:0] cl,
                                          input logic [15:0] len);
    sct_pkg::result_t r;
    r.kind = k;
    r.err  = e;
    r.line = sat16(ln);
    r.col  = sat16(cl);
    r.len  = len;
    r.last = 1'b0;
    return r;
  endfunction

  logic is_digit, is_alpha, is_space;
  logic consumed;
  logic a_v, b_v, c_v;
  sct_pkg::result_t a_r, b_r, c_r;

  assign is_digit = (ch_i >= 8'h30) && (ch_i <= 8'h39);
  assign is_alpha = ((ch_i >= 8'h61) && (ch_i <= 8'h7A)) ||
                    ((ch_i >= 8'h41) && (ch_i <= 8'h5A));
  assign is_space = (ch_i == 8'h20) || ((ch_i >= 8'h09) && (ch_i <= 8'h0D));

  always_comb begin
    consumed    = 1'b0;
    a_v         = 1'b0;
    b_v         = 1'b0;
    c_v         = 1'b0;
    a_r         = '0;
    b_r         = '0;
    c_r         = '0;
    mode_o      = mode_i;
    run_len_o   = run_len_i;
    line_o      = line_i;
    col_o       = col_i;
    prev_line_o = prev_line_i;
    prev_col_o  = prev_col_i;

    if (mode_i == sct_pkg::ModeError) begin
      if (eos_i) begin
        mode_o      = sct_pkg::ModeIdle;
        run_len_o   = '0;
        line_o      = '0;
        col_o       = '0;
        prev_line_o = '0;
        prev_col_o  = '0;
      end
    end else begin
      case (mode_i)
        sct_pkg::ModeNumber: begin
          if (is_digit) begin
            consumed  = 1'b1;
            run_len_o = len_inc(run_len_i);
          end else begin
            a_v    = 1'b1;
            a_r    = mk(sct_pkg::KindNumber, sct_pkg::ErrNone, prev_line_i, prev_col_i,
                        run_len_i);
            mode_o = sct_pkg::ModeIdle;
          end
        end
        sct_pkg::ModeIdent: begin
          if (is_alpha || is_digit || ch_i == sct_pkg::ChUnderscore) begin
            consumed  = 1'b1;
            run_len_o = len_inc(run_len_i);
          end else begin
            a_v    = 1'b1;
            a_r    = mk(sct_pkg::KindIdent, sct_pkg::ErrNone, prev_line_i, prev_col_i,
                        run_len_i);
            mode_o = sct_pkg::ModeIdle;
          end
        end
        sct_pkg::ModeText: begin
          consumed = 1'b1;
          if (ch_i == sct_pkg::ChQuote) begin
            a_v    = 1'b1;
            a_r    = mk(sct_pkg::KindText, sct_pkg::ErrNone, line_i, col_i, run_len_i);
            mode_o = sct_pkg::ModeIdle;
          end else begin
            run_len_o = len_inc(run_len_i);
          end
        end
        sct_pkg::ModeComment: begin
          consumed = 1'b1;
          if (ch_i == sct_pkg::ChNewline) mode_o = sct_pkg::ModeIdle;
        end
        sct_pkg::ModeSlash: begin
          consumed = 1'b1;
          if (ch_i == sct_pkg::ChSlash) begin
            mode_o = sct_pkg::ModeComment;
          end else begin
            a_v    = 1'b1;
            a_r    = mk(sct_pkg::KindError, sct_pkg::ErrLoneSlash, prev_line_i,
                        prev_col_i, 16'd1);
            mode_o = sct_pkg::ModeError;
          end
        end
        default: mode_o = sct_pkg::ModeIdle;
      endcase

      if (!consumed) begin
        if (is_space) begin
          b_v = 1'b0;
        end else if (ch_i == sct_pkg::ChLparen) begin
          b_v = 1'b1;
          b_r = mk(sct_pkg::KindLparen, sct_pkg::ErrNone, line_i, col_i, 16'd1);
        end else if (ch_i == sct_pkg::ChRparen) begin
          b_v = 1'b1;
          b_r = mk(sct_pkg::KindRparen, sct_pkg::ErrNone, line_i, col_i, 16'd1);
        end else if (ch_i == sct_pkg::ChSemi) begin
          b_v = 1'b1;
          b_r = mk(sct_pkg::KindSemi, sct_pkg::ErrNone, line_i, col_i, 16'd1);
        end else if (ch_i == sct_pkg::ChEquals) begin
          b_v = 1'b1;
          b_r = mk(sct_pkg::KindEquals, sct_pkg::ErrNone, line_i, col_i, 16'd1);
        end else if (ch_i == sct_pkg::ChQuote) begin
          mode_o    = sct_pkg::ModeText;
          run_len_o = '0;
        end else if (ch_i == sct_pkg::ChSlash) begin
          mode_o = sct_pkg::ModeSlash;
        end else if (is_digit) begin
          mode_o    = sct_pkg::ModeNumber;
          run_len_o = 16'd1;
        end else if (is_alpha) begin
          mode_o    = sct_pkg::ModeIdent;
          run_len_o = 16'd1;
        end else begin
          b_v    = 1'b1;
          b_r    = mk(sct_pkg::KindError, sct_pkg::ErrUnknown, line_i, col_i, 16'd1);
          mode_o = sct_pkg::ModeError;
        end
      end

      prev_line_o = line_i;
      prev_col_o  = col_i;
      if (ch_i == sct_pkg::ChNewline) begin
        line_o = pos_inc(line_i);
        col_o  = '0;
      end else begin
        col_o = pos_inc(col_i);
      end

      if (eos_i) begin
        case (mode_o)
          sct_pkg::ModeNumber: begin
            c_v = 1'b1;
            c_r = mk(sct_pkg::KindNumber, sct_pkg::ErrNone, line_i, col_i, run_len_o);
          end
          sct_pkg::ModeIdent: begin
            c_v = 1'b1;
            c_r = mk(sct_pkg::KindIdent, sct_pkg::ErrNone, line_i, col_i, run_len_o);
          end
          sct_pkg::ModeText: begin
            c_v = 1'b1;
            c_r = mk(sct_pkg::KindError, sct_pkg::ErrUnterminated, line_i, col_i,
                     run_len_o);
          end
          sct_pkg::ModeSlash: begin
            c_v = 1'b1;
            c_r = mk(sct_pkg::KindError, sct_pkg::ErrLoneSlash, line_i, col_i, 16'd1);
          end
          default: c_v = 1'b0;
        endcase
        mode_o      = sct_pkg::ModeIdle;
        run_len_o   = '0;
        line_o      = '0;
        col_o       = '0;
        prev_line_o = '0;
        prev_col_o  = '0;
      end
    end
  end

  // pack results in order: pending token, this byte, end-of-source flush
  always_comb begin
    push_o      = '0;
    push_o.cnt  = 2'(a_v) + 2'(b_v) + 2'(c_v);
    if (a_v) begin
      push_o.res0 = a_r;
      push_o.res1 = b_v ? b_r : c_r;
    end else if (b_v) begin
      push_o.res0 = b_r;
      push_o.res1 = c_r;
    end else begin
      push_o.res0 = c_r;
    end
    case (push_o.cnt)
      2'd1:    push_o.res0.last = 1'b1;
      2'd2:    push_o.res1.last = 1'b1;
      default: push_o.res0.last = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/sct_out_fifo.sv
`default_nettype none

`include "source_char_tokenizer_defines.svh"

module sct_out_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sct_pkg::push_t  push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output sct_pkg::result_t     data_o
);

  localparam int Depth = sct_pkg::FifoDepth;
  localparam int PtrW  = sct_pkg::FifoPtrW;
  localparam int CntW  = sct_pkg::FifoCntW;

  sct_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CntW'(Depth - 2));
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.cnt);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + CntW'(push_i.cnt) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q] <= push_i.res0;
    if (push_i.cnt == 2'd2) mem_q[wr_ptr_q + PtrW'(1)] <= push_i.res1;
  end

  `SCT_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(Depth), "fifo over depth")
  `SCT_ASSERT_IMPL(a_push_room, clk_i, rst_ni, push_i.cnt != 2'd0, room_o, "push without room")
  `SCT_ASSERT_NEXT(a_pop_only, clk_i, rst_ni, pop && push_i.cnt == 2'd0, cnt_q == $past(cnt_q) - CntW'(1), "pop count slip")

endmodule

`default_nettype wire

### rtl/core/source_char_tokenizer.sv
// Channel  Handshake                Beat contents
// -------  -----------------------  ---------------------------------------------
// in       in_valid_i / in_ready_o  ch_i, end_of_source_i
// out      out_valid_o / out_ready_i token_kind_o, error_code_o, line_number_o,
//                                    column_number_o, token_length_o, last_of_run_o
//
// One byte per cycle is taken into an input register while the queue has room; the scan
// step runs on it in the next cycle and, when the queue has room, writes zero, one or two
// results into a four-entry output queue. Sustained rate is one byte per cycle while the
// queue has room; the queue drains one result per cycle, set by the single output port.
// A stalled output backs up the queue; input stalls once the queue holds three or more.
// Reset (rst_ni, async low) clears mode, counters, queue and input valid; no sweep.
`default_nettype none

`include "source_char_tokenizer_defines.svh"

module source_char_tokenizer #(
  parameter int POSITION_BITS = sct_pkg::PositionBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        end_of_source_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       token_kind_o,
  output logic [1:0]       error_code_o,
  output logic [15:0]      line_number_o,
  output logic [15:0]      column_number_o,
  output logic [15:0]      token_length_o,
  output logic             last_of_run_o
);

  logic                     stg_valid_q;
  logic [7:0]               stg_ch_q;
  logic                     stg_eos_q;
  logic                     stg_fire;

  logic [2:0]               mode_q, mode_d;
  logic [15:0]              run_len_q, run_len_d;
  logic [POSITION_BITS-1:0] line_q, line_d;
  logic [POSITION_BITS-1:0] col_q, col_d;
  logic [POSITION_BITS-1:0] prev_line_q, prev_line_d;
  logic [POSITION_BITS-1:0] prev_col_q, prev_col_d;

  sct_pkg::push_t           step_push, fifo_push;
  sct_pkg::result_t         head;
  logic                     fifo_room;

  assign stg_fire   = stg_valid_q && fifo_room;
  assign in_ready_o = !stg_valid_q || stg_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_ch_q  <= ch_i;
      stg_eos_q <= end_of_source_i;
    end
  end

  sct_step #(
    .PosBits(POSITION_BITS)
  ) u_step (
    .ch_i       (stg_ch_q),
    .eos_i      (stg_eos_q),
    .mode_i     (mode_q),
    .run_len_i  (run_len_q),
    .line_i     (line_q),
    .col_i      (col_q),
    .prev_line_i(prev_line_q),
    .prev_col_i (prev_col_q),
    .mode_o     (mode_d),
    .run_len_o  (run_len_d),
    .line_o     (line_d),
    .col_o      (col_d),
    .prev_line_o(prev_line_d),
    .prev_col_o (prev_col_d),
    .push_o     (step_push)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= sct_pkg::ModeIdle;
      run_len_q   <= '0;
      line_q      <= '0;
      col_q       <= '0;
      prev_line_q <= '0;
      prev_col_q  <= '0;
    end else if (stg_fire) begin
      mode_q      <= mode_d;
      run_len_q   <= run_len_d;
      line_q      <= line_d;
      col_q       <= col_d;
      prev_line_q <= prev_line_d;
      prev_col_q  <= prev_col_d;
    end
  end

  always_comb begin
    fifo_push = step_push;
    if (!stg_fire) fifo_push.cnt = 2'd0;
  end

  sct_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .room_o (fifo_room),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (head)
  );

  assign token_kind_o    = head.kind;
  assign error_code_o    = head.err;
  assign line_number_o   = head.line;
  assign column_number_o = head.col;
  assign token_length_o  = head.len;
  assign last_of_run_o   = head.last;

  `SCT_ASSERT_NEXT(a_stg_hold, clk_i, rst_ni, stg_valid_q && !stg_fire, stg_valid_q && $stable(stg_ch_q), "stalled byte lost")
  `SCT_ASSERT_IMPL(a_err_quiet, clk_i, rst_ni, stg_fire && mode_q == sct_pkg::ModeError, fifo_push.cnt == 2'd0, "result while in error")
  `SCT_ASSERT_NEXT(a_eos_clear, clk_i, rst_ni, stg_fire && stg_eos_q, mode_q == sct_pkg::ModeIdle && line_q == '0 && col_q == '0, "end of source left state")

endmodule

`default_nettype wire

### bench/sct_token_check.sv
module sct_token_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  ch_i,
  input  logic        end_of_source_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  token_kind_i,
  input  logic [1:0]  error_code_i,
  input  logic [15:0] line_number_i,
  input  logic [15:0] column_number_i,
  input  logic [15:0] token_length_i,
  input  logic        last_of_run_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  logic [2:0]       mode;
  logic [15:0]      line_cnt;
  logic [15:0]      col_cnt;
  logic [15:0]      run_len;
  logic [15:0]      prev_line;
  logic [15:0]      prev_col;
  sct_pkg::result_t tokens_due[$];
  sct_pkg::result_t want;
  int               token_no;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic sct_pkg::result_t make_token(sct_pkg::kind_e k, sct_pkg::err_e er,
                                                  logic [15:0] ln, logic [15:0] cl,
                                                  logic [15:0] len);
    sct_pkg::result_t r;
    r.kind = k;
    r.err  = er;
    r.line = ln;
    r.col  = cl;
    r.len  = len;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic clear_scan();
    mode      = sct_pkg::ModeIdle;
    line_cnt  = '0;
    col_cnt   = '0;
    run_len   = '0;
    prev_line = '0;
    prev_col  = '0;
  endtask

  task automatic report_mismatch(string what);
    $display("token %0d: %s", token_no, what);
    fail_count_o++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, exp_val));
    end
  endtask

  // Advance the scanner by one byte and queue the tokens it yields.
  task automatic scan_byte(input logic [7:0] c, input logic e);
    sct_pkg::result_t burst[$];
    logic [15:0]      ln;
    logic [15:0]      cl;
    logic             taken;
    ln = line_cnt;
    cl = col_cnt;
    taken = 1'b0;
    if (mode == sct_pkg::ModeError) begin
      if (e) clear_scan();
    end else begin
      case (mode)
        sct_pkg::ModeNumber: begin
          if (is_digit(c)) begin
            taken = 1'b1;
            if (run_len != '1) run_len++;
          end else begin
            burst = {burst, make_token(sct_pkg::KindNumber, sct_pkg::ErrNone, prev_line,
                                       prev_col, run_len)};
            mode = sct_pkg::ModeIdle;
          end
        end
        sct_pkg::ModeIdent: begin
          if (is_alpha(c) || is_digit(c) || c == sct_pkg::ChUnderscore) begin
            taken = 1'b1;
            if (run_len != '1) run_len++;
          end else begin
            burst = {burst, make_token(sct_pkg::KindIdent, sct_pkg::ErrNone, prev_line,
                                       prev_col, run_len)};
            mode = sct_pkg::ModeIdle;
          end
        end
        sct_pkg::ModeText: begin
          taken = 1'b1;
          if (c == sct_pkg::ChQuote) begin
            burst = {burst, make_token(sct_pkg::KindText, sct_pkg::ErrNone, ln, cl,
                                       run_len)};
            mode = sct_pkg::ModeIdle;
          end else if (run_len != '1) begin
            run_len++;
          end
        end
        sct_pkg::ModeComment: begin
          taken = 1'b1;
          if (c == sct_pkg::ChNewline) mode = sct_pkg::ModeIdle;
        end
        sct_pkg::ModeSlash: begin
          taken = 1'b1;
          if (c == sct_pkg::ChSlash) begin
            mode = sct_pkg::ModeComment;
          end else begin
            burst = {burst, make_token(sct_pkg::KindError, sct_pkg::ErrLoneSlash, prev_line,
                                       prev_col, 16'd1)};
            mode = sct_pkg::ModeError;
          end
        end
        default: mode = sct_pkg::ModeIdle;
      endcase

      if (!taken) begin
        if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
        end else if (c == sct_pkg::ChLparen) begin
          burst = {burst, make_token(sct_pkg::KindLparen, sct_pkg::ErrNone, ln, cl, 16'd1)};
        end else if (c == sct_pkg::ChRparen) begin
          burst = {burst, make_token(sct_pkg::KindRparen, sct_pkg::ErrNone, ln, cl, 16'd1)};
        end else if (c == sct_pkg::ChSemi) begin
          burst = {burst, make_token(sct_pkg::KindSemi, sct_pkg::ErrNone, ln, cl, 16'd1)};
        end else if (c == sct_pkg::ChEquals) begin
          burst = {burst, make_token(sct_pkg::KindEquals, sct_pkg::ErrNone, ln, cl, 16'd1)};
        end else if (c == sct_pkg::ChQuote) begin
          mode = sct_pkg::ModeText;
          run_len = '0;
        end else if (c == sct_pkg::ChSlash) begin
          mode = sct_pkg::ModeSlash;
        end else if (is_digit(c)) begin
          mode = sct_pkg::ModeNumber;
          run_len = 16'd1;
        end else if (is_alpha(c)) begin
          mode = sct_pkg::ModeIdent;
          run_len = 16'd1;
        end else begin
          burst = {burst, make_token(sct_pkg::KindError, sct_pkg::ErrUnknown, ln, cl,
                                     16'd1)};
          mode = sct_pkg::ModeError;
        end
      end

      prev_line = ln;
      prev_col  = cl;
      if (c == sct_pkg::ChNewline) begin
        if (line_cnt != '1) line_cnt++;
        col_cnt = '0;
      end else if (col_cnt != '1) begin
        col_cnt++;
      end

      if (e) begin
        case (mode)
          sct_pkg::ModeNumber:
            burst = {burst, make_token(sct_pkg::KindNumber, sct_pkg::ErrNone, prev_line,
                                       prev_col, run_len)};
          sct_pkg::ModeIdent:
            burst = {burst, make_token(sct_pkg::KindIdent, sct_pkg::ErrNone, prev_line,
                                       prev_col, run_len)};
          sct_pkg::ModeText:
            burst = {burst, make_token(sct_pkg::KindError, sct_pkg::ErrUnterminated,
                                       prev_line, prev_col, run_len)};
          sct_pkg::ModeSlash:
            burst = {burst, make_token(sct_pkg::KindError, sct_pkg::ErrLoneSlash,
                                       prev_line, prev_col, 16'd1)};
          default: ;
        endcase
        clear_scan();
      end

      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) tokens_due = {tokens_due, burst[i]};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      tokens_due.delete();
      fail_count_o = 0;
      token_no = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (tokens_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat kind %0d at %0d:%0d", token_kind_i,
                                    line_number_i, column_number_i));
        end else begin
          want = tokens_due.pop_front();
          check_field("kind", 16'(token_kind_i), 16'(want.kind));
          check_field("error", 16'(error_code_i), 16'(want.err));
          check_field("line", line_number_i, want.line);
          check_field("column", column_number_i, want.col);
          check_field("length", token_length_i, want.len);
          check_field("last", 16'(last_of_run_i), 16'(want.last));
        end
        token_no++;
      end
      if (in_valid_i && in_ready_i) scan_byte(ch_i, end_of_source_i);
      pending_o <= tokens_due.size();
    end
  end

endmodule

### bench/tb_source_char_tokenizer.sv
module tb_source_char_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int RandomBytes = 600;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  ch;
  logic        eos;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  tok_kind;
  logic [1:0]  tok_err;
  logic [15:0] tok_line;
  logic [15:0] tok_col;
  logic [15:0] tok_len;
  logic        tok_last;
  int          fail_count;
  int          pending;

  int unsigned cycles = 0;
  int          stall_style = 0;
  int          style_left = 0;
  int          burst_left = 0;
  logic        steady = 1'b1;
  logic [7:0]  src[$];

  always #5 clk = ~clk;

  source_char_tokenizer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .ch_i           (ch),
    .end_of_source_i(eos),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .token_kind_o   (tok_kind),
    .error_code_o   (tok_err),
    .line_number_o  (tok_line),
    .column_number_o(tok_col),
    .token_length_o (tok_len),
    .last_of_run_o  (tok_last)
  );

  sct_token_check u_token_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .ch_i           (ch),
    .end_of_source_i(eos),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .token_kind_i   (tok_kind),
    .error_code_i   (tok_err),
    .line_number_i  (tok_line),
    .column_number_i(tok_col),
    .token_length_i (tok_len),
    .last_of_run_i  (tok_last),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_source_char_tokenizer: FAIL");
      $finish;
    end
  end

  // Receiver backpressure: switch style each time the randomly drawn hold count runs out.
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      style_left  <= $urandom_range(50, 400);
    end else begin
      style_left <= style_left - 1;
    end
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) > 2);
      2: out_ready <= ((cycles % 7) > 2);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [7:0] rand_alpha();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_word_char();
    int k;
    k = $urandom_range(0, 5);
    if (k == 0) return sct_pkg::ChUnderscore;
    if (k < 3) return 8'("0" + $urandom_range(0, 9));
    return rand_alpha();
  endfunction

  function automatic logic [7:0] rand_text_char();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == sct_pkg::ChQuote) ? 8'h27 : b;
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic e);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    ch       <= c;
    eos      <= e;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_source();
    foreach (src[i]) send_beat(src[i], i == src.size() - 1);
    src.delete();
  endtask

  task automatic add_byte(input logic [7:0] b);
    src = {src, b};
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Mostly well-formed tokens with random content; a little noise.
  task automatic build_source();
    int         n_tok;
    int         k;
    logic [7:0] b;
    n_tok = $urandom_range(3, 20);
    repeat (n_tok) begin
      k = $urandom_range(0, 39);
      if (k < 8) begin
        add_byte(rand_alpha());
        repeat ($urandom_range(0, 6)) add_byte(rand_word_char());
      end else if (k < 14) begin
        repeat ($urandom_range(1, 5)) add_byte(8'("0" + $urandom_range(0, 9)));
      end else if (k < 18) begin
        add_byte(sct_pkg::ChQuote);
        repeat ($urandom_range(0, 5)) add_byte(rand_text_char());
        add_byte(sct_pkg::ChQuote);
      end else if (k < 20) begin
        add_byte(sct_pkg::ChSlash);
        add_byte(sct_pkg::ChSlash);
        repeat ($urandom_range(0, 6)) begin
          b = 8'($urandom_range(0, 255));
          add_byte((b == sct_pkg::ChNewline) ? 8'h20 : b);
        end
        add_byte(sct_pkg::ChNewline);
      end else if (k < 28) begin
        case ($urandom_range(0, 3))
          0: add_byte(sct_pkg::ChLparen);
          1: add_byte(sct_pkg::ChRparen);
          2: add_byte(sct_pkg::ChSemi);
          default: add_byte(sct_pkg::ChEquals);
        endcase
      end else if (k < 38) begin
        k = $urandom_range(0, 5);
        add_byte((k == 0) ? 8'h20 : 8'(8'h09 + k - 1));
      end else if (k == 38) begin
        add_byte(sct_pkg::ChSlash);
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      add_byte(sct_pkg::ChQuote);
      repeat ($urandom_range(0, 4)) add_byte(rand_text_char());
    end
  endtask

  initial begin
    int random_beats;
    random_beats = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    ch        = 8'h00;
    eos       = 1'b0;
    out_ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every token kind, flush by a following byte, text across a newline,
    // comment closed by newline, lone slash with dropped byte, ignore after error.
    add_str("(x_9)12;=\"\na\"//z\n/q");
    add_byte(8'h00);
    add_byte(8'h20);
    send_source();
    add_str("\"b");
    send_source();
    add_byte(8'hFF);
    send_source();
    add_byte(sct_pkg::ChUnderscore);
    add_byte(8'h80);
    send_source();
    add_str("7");
    send_source();
    add_byte(sct_pkg::ChSlash);
    send_source();
    add_str("k");
    send_source();

    while (random_beats < RandomBytes) begin
      steady = ($urandom_range(0, 3) == 0);
      build_source();
      random_beats += src.size();
      send_source();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_source_char_tokenizer: PASS");
    end else begin
      $display("tb_source_char_tokenizer: FAIL");
    end
    $finish;
  end

endmodule
